>>> hdl/srrip_pkg.sv
// ----------------------------------------------------------------------------
// srrip_pkg
// shared sizes, command codes and row types of the static rrip replacement
// ----------------------------------------------------------------------------
package srrip_pkg;

	// geometry of the tracked cache
	localparam int NUM_SETS = 64;
	localparam int NUM_WAYS = 8;

	// transaction field widths
	localparam int CMD_W     = 2;
	localparam int SET_IDX_W = 6;
	localparam int WAY_IDX_W = 3;

	// internal address widths
	localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_AW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

	// prediction values
	localparam logic [1:0] RRPV_NEAR    = 2'd0;
	localparam logic [1:0] RRPV_LONG    = 2'd2;
	localparam logic [1:0] RRPV_DISTANT = 2'd3;

	// command codes
	localparam logic [CMD_W-1:0] CMD_HIT    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd2;

	// one set row: a 2-bit value per way
	typedef logic [NUM_WAYS-1:0][1:0] rrpv_row_t;

	// row write port
	typedef struct packed {
		logic              en;
		logic [SET_AW-1:0] addr;
		rrpv_row_t         data;
	} row_wr_t;

	// update of one row
	typedef struct packed {
		logic                 wr_en;
		rrpv_row_t            row;
		logic [WAY_IDX_W-1:0] victim_way;
	} row_upd_t;

endpackage

>>> hdl/srrip_req_if.sv
// ----------------------------------------------------------------------------
// srrip_req_if
// command channel: hit, insert or victim request for one set
// ----------------------------------------------------------------------------
interface srrip_req_if import srrip_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     cmd;
	logic [SET_IDX_W-1:0] set_index;
	logic [WAY_IDX_W-1:0] way;

	modport source (output valid, output cmd, output set_index, output way, input ready);
	modport sink (input valid, input cmd, input set_index, input way, output ready);
endinterface

>>> hdl/srrip_rsp_if.sv
// ----------------------------------------------------------------------------
// srrip_rsp_if
// result channel: chosen victim way
// ----------------------------------------------------------------------------
interface srrip_rsp_if import srrip_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [WAY_IDX_W-1:0] victim_way;

	modport source (output valid, output victim_way, input ready);
	modport sink (input valid, input victim_way, output ready);
endinterface

>>> hdl/srrip_row_mem.sv
// ----------------------------------------------------------------------------
// srrip_row_mem
// set row memory, registered read, per-row valid bits for reset value
// ----------------------------------------------------------------------------
module srrip_row_mem import srrip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [SET_AW-1:0] rd_addr,
	input  row_wr_t           wr,
	output rrpv_row_t         rd_row
);

	rrpv_row_t             mem [NUM_SETS];
	rrpv_row_t             rd_mem_q;
	logic                  rd_vld_q;
	logic [NUM_SETS-1:0]   row_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_mem_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				row_vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	// unwritten rows read as all distant
	assign rd_row = rd_vld_q ? rd_mem_q : {NUM_WAYS{RRPV_DISTANT}};

endmodule

>>> hdl/srrip_row_update.sv
// ----------------------------------------------------------------------------
// srrip_row_update
// modify step: promote, insert, or age a row and pick the victim way
// ----------------------------------------------------------------------------
module srrip_row_update import srrip_pkg::*; (
	input  logic [CMD_W-1:0]     cmd,
	input  logic                 set_ok,
	input  logic [WAY_IDX_W-1:0] way,
	input  rrpv_row_t            row,
	output row_upd_t             upd
);

	logic                 way_ok;
	logic [WAY_AW-1:0]    way_idx;
	logic                 top_hi;
	logic                 top_lo;
	logic [1:0]           age;
	logic [2:0]           sum;
	rrpv_row_t            aged;
	rrpv_row_t            marked;
	logic [WAY_IDX_W-1:0] vic;

	assign way_ok  = 32'(way) < NUM_WAYS;
	assign way_idx = WAY_AW'(way);

	// largest value of the row, bit by bit
	always_comb begin
		top_hi = 1'b0;
		top_lo = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			top_hi = top_hi | row[w][1];
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			top_lo = top_lo | (row[w][0] & (row[w][1] == top_hi));
		end
		age = RRPV_DISTANT - {top_hi, top_lo};
	end

	// saturating age and lowest way at distant
	always_comb begin
		aged = row;
		vic  = '0;
		sum  = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			sum     = {1'b0, row[w]} + {1'b0, age};
			aged[w] = (sum > {1'b0, RRPV_DISTANT}) ? RRPV_DISTANT : sum[1:0];
		end
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (aged[w] == RRPV_DISTANT) begin
				vic = WAY_IDX_W'(w);
			end
		end
	end

	always_comb begin
		marked = row;
		marked[way_idx] = (cmd == CMD_HIT) ? RRPV_NEAR : RRPV_LONG;
	end

	always_comb begin
		upd.wr_en      = 1'b0;
		upd.row        = row;
		upd.victim_way = '0;
		unique case (cmd)
			CMD_HIT, CMD_INSERT: begin
				upd.wr_en = set_ok & way_ok;
				upd.row   = marked;
			end
			CMD_VICTIM: begin
				upd.wr_en      = set_ok;
				upd.row        = aged;
				upd.victim_way = set_ok ? vic : '0;
			end
			default: begin
				upd.wr_en = 1'b0;
			end
		endcase
	end

endmodule

>>> hdl/srrip_replacement_policy.sv
// ----------------------------------------------------------------------------
// srrip_replacement_policy
// static rrip replacement state with 2-bit prediction values per way
// ----------------------------------------------------------------------------
// Keeps a 2-bit re-reference prediction value for each way of every set, all
// distant (3) after reset. A hit transaction sets the named way to 0, an insert
// sets it to 2, and a victim transaction ages the whole set until its largest
// value is 3, writes the set back and returns the lowest way now at 3. Only
// victim transactions produce a result. Each transaction first reads the set row
// from the synchronous row memory, then modifies it and writes it back; a new
// transaction is only taken once the last one has finished. No clearing pass
// follows reset; per-row valid bits stand in for the reset value.
// A pending result sits in an output register; a victim transaction waits in
// its write-back cycle only while that register is still full.
module srrip_replacement_policy import srrip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	srrip_req_if.sink   req,
	srrip_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RMW  = 2'b10
	} state_t;

	state_t               state_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [WAY_IDX_W-1:0] way_q;
	logic [SET_AW-1:0]    set_q;
	logic                 set_ok_q;
	logic                 rsp_valid_q;
	logic [WAY_IDX_W-1:0] victim_q;

	logic                 req_fire;
	logic                 set_ok_in;
	logic [SET_AW-1:0]    set_addr_in;
	logic                 out_blocked;
	logic                 finish;
	rrpv_row_t            rd_row;
	row_upd_t             upd;
	row_wr_t              wr;

	assign req.ready   = (state_q == S_IDLE);
	assign req_fire    = req.valid & req.ready;
	assign set_ok_in   = 32'(req.set_index) < NUM_SETS;
	assign set_addr_in = SET_AW'(req.set_index);

	// a victim result needs a free output register
	assign out_blocked = (cmd_q == CMD_VICTIM) & rsp_valid_q & ~rsp.ready;
	assign finish      = (state_q == S_RMW) & ~out_blocked;

	// row read issued at transaction acceptance
	srrip_row_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (req_fire),
		.rd_addr (set_addr_in),
		.wr      (wr),
		.rd_row  (rd_row)
	);

	srrip_row_update u_upd (
		.cmd    (cmd_q),
		.set_ok (set_ok_q),
		.way    (way_q),
		.row    (rd_row),
		.upd    (upd)
	);

	// write back in the modify cycle
	always_comb begin
		wr.en   = finish & upd.wr_en;
		wr.addr = set_q;
		wr.data = upd.row;
	end

	// captured transaction fields
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q    <= req.cmd;
			way_q    <= req.way;
			set_q    <= set_addr_in;
			set_ok_q <= set_ok_in;
		end
		if (finish && cmd_q == CMD_VICTIM) begin
			victim_q <= upd.victim_way;
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_RMW;
					end
				end
				S_RMW: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (finish && cmd_q == CMD_VICTIM) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.victim_way = victim_q;

endmodule
